// ===== rtl/cpf_pkg.sv =====
`default_nettype none
package cpf_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int FRAC_BITS   = 16;

  // quotient bits kept by the divider; anything larger saturates the result
  localparam int QUOT_BITS   = COORD_WIDTH + 2;
  localparam int NUM_W       = 3 * COORD_WIDTH + 2;
  localparam int DEN_W       = 2 * COORD_WIDTH;

  localparam logic [1:0] ACT_DOT    = 2'd0;
  localparam logic [1:0] ACT_CIRCLE = 2'd1;
  localparam logic [1:0] ACT_LINE   = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_DEGEN = 2'd1;
  localparam logic [1:0] ST_SAT   = 2'd2;

  typedef struct packed {
    logic [1:0]                    action;
    logic signed [COORD_WIDTH-1:0] point_x;
    logic signed [COORD_WIDTH-1:0] point_y;
    logic signed [COORD_WIDTH-1:0] center_x;
    logic signed [COORD_WIDTH-1:0] center_y;
    logic [COORD_WIDTH-2:0]        radius;
    logic signed [COORD_WIDTH-1:0] coef_a;
    logic signed [COORD_WIDTH-1:0] coef_b;
    logic signed [COORD_WIDTH-1:0] coef_c;
  } in_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] near_x;
    logic signed [COORD_WIDTH-1:0] near_y;
    logic [1:0]                    status;
  } out_t;

  // what the final add needs besides the quotients
  typedef struct packed {
    logic [1:0]             status;
    logic [COORD_WIDTH-1:0] base_x;
    logic [COORD_WIDTH-1:0] base_y;
    logic                   neg_x;
    logic                   neg_y;
  } side_t;

endpackage
`default_nettype wire

// ===== rtl/cpf_div.sv =====
`default_nettype none
module cpf_div (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           adv,
  input  wire logic                           in_valid,
  input  wire logic [cpf_pkg::NUM_W-1:0]      num_x,
  input  wire logic [cpf_pkg::NUM_W-1:0]      num_y,
  input  wire logic [cpf_pkg::DEN_W-1:0]      den,
  input  wire cpf_pkg::side_t                 side,
  output logic                                out_valid,
  output logic [cpf_pkg::QUOT_BITS:0]         quot_x,
  output logic [cpf_pkg::QUOT_BITS:0]         quot_y,
  output cpf_pkg::side_t                      side_out
);

  localparam int QB    = cpf_pkg::QUOT_BITS;
  localparam int NW    = cpf_pkg::NUM_W;
  localparam int DW    = cpf_pkg::DEN_W;
  localparam int REM_W = DW + 1;

  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [QB-1:0]    nlow;
    logic [QB-1:0]    q;
    logic             ovf;
  } lane_t;

  typedef struct packed {
    lane_t           x;
    lane_t           y;
    logic [DW-1:0]   den;
    cpf_pkg::side_t  side;
  } dst_t;

  function automatic lane_t lane_init(logic [NW-1:0] n, logic [DW-1:0] d);
    lane_t l;
    l.ovf  = n >= {d, {QB{1'b0}}};
    l.rem  = {1'b0, n[NW-1:QB]};
    l.nlow = n[QB-1:0];
    l.q    = '0;
    return l;
  endfunction

  function automatic lane_t lane_step(lane_t l, logic [DW-1:0] d);
    lane_t        o;
    logic [REM_W-1:0] sh;
    logic         ge;
    sh     = {l.rem[REM_W-2:0], l.nlow[QB-1]};
    ge     = sh >= {1'b0, d};
    o.rem  = ge ? sh - {1'b0, d} : sh;
    o.nlow = {l.nlow[QB-2:0], 1'b0};
    o.q    = {l.q[QB-2:0], ge};
    o.ovf  = l.ovf;
    return o;
  endfunction

  // round half up on the magnitude; an overflowed lane gets a value that saturates
  function automatic logic [QB:0] lane_round(lane_t l, logic [DW-1:0] d);
    logic up;
    up = {l.rem, 1'b0} >= {2'b00, d};
    if (l.ovf) begin
      return {1'b1, {QB{1'b0}}};
    end
    return {1'b0, l.q} + {{QB{1'b0}}, up};
  endfunction

  logic  v_r  [QB+1];
  dst_t  st_r [QB+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (adv) begin
      v_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st_r[0].x    <= lane_init(num_x, den);
      st_r[0].y    <= lane_init(num_y, den);
      st_r[0].den  <= den;
      st_r[0].side <= side;
    end
  end

  for (genvar k = 0; k < QB; k++) begin : g_step
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k+1] <= 1'b0;
      end else if (adv) begin
        v_r[k+1] <= v_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        st_r[k+1].x    <= lane_step(st_r[k].x, st_r[k].den);
        st_r[k+1].y    <= lane_step(st_r[k].y, st_r[k].den);
        st_r[k+1].den  <= st_r[k].den;
        st_r[k+1].side <= st_r[k].side;
      end
    end
  end

  logic          out_valid_r;
  logic [QB:0]   quot_x_r;
  logic [QB:0]   quot_y_r;
  cpf_pkg::side_t side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= v_r[QB];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      quot_x_r <= lane_round(st_r[QB].x, st_r[QB].den);
      quot_y_r <= lane_round(st_r[QB].y, st_r[QB].den);
      side_r   <= st_r[QB].side;
    end
  end

  assign out_valid = out_valid_r;
  assign quot_x    = quot_x_r;
  assign quot_y    = quot_y_r;
  assign side_out  = side_r;

endmodule
`default_nettype wire

// ===== rtl/closest_point_on_figure_unit.sv =====
// Nearest point on a dot, circle or line to a query point, Q16.16.
// The square root and the divider each resolve one bit per stage.
// Throughput: one beat per cycle; a stalled output holds the whole pipeline.
// Reset: synchronous, active low; clears all valid bits, no payload reset.
`default_nettype none
module closest_point_on_figure_unit (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire cpf_pkg::in_t   in_data,
  output logic                out_valid,
  input  wire logic           out_stall,
  output cpf_pkg::out_t       out_data
);

  localparam int W      = cpf_pkg::COORD_WIDTH;
  localparam int ROOT_W = W + 1;
  localparam int SQ_W   = 2 * ROOT_W;
  localparam int SREM_W = W + 3;
  localparam int E_W    = 2 * W + 2;
  localparam int EMAG_W = 2 * W + 1;
  localparam int ELO_W  = W;
  localparam int DW     = cpf_pkg::DEN_W;
  localparam int NW     = cpf_pkg::NUM_W;
  localparam int QB     = cpf_pkg::QUOT_BITS;
  localparam int SUM_W  = W + 4;

  typedef struct packed {
    logic                is_circ;
    logic                is_line;
    logic signed [W-1:0] px;
    logic signed [W-1:0] py;
    logic [W-1:0]        cx;
    logic [W-1:0]        cy;
    logic [W-2:0]        rad;
    logic signed [W-1:0] a;
    logic signed [W-1:0] b;
    logic [W-1:0]        c;
    logic [W:0]          opx;
    logic [W:0]          opy;
    logic                negx;
    logic                negy;
  } s2_t;

  typedef struct packed {
    logic                is_circ;
    logic                is_line;
    logic [W-1:0]        px;
    logic [W-1:0]        py;
    logic [W-1:0]        cx;
    logic [W-1:0]        cy;
    logic [W-2:0]        rad;
    logic [W-1:0]        c;
    logic [W:0]          opx;
    logic [W:0]          opy;
    logic                negx;
    logic                negy;
    logic [SQ_W-1:0]     sqx;
    logic [SQ_W-1:0]     sqy;
    logic [2*W-1:0]      apx;
    logic [2*W-1:0]      bpy;
  } s3_t;

  typedef struct packed {
    logic                is_circ;
    logic                is_line;
    logic [W-1:0]        px;
    logic [W-1:0]        py;
    logic [W-1:0]        cx;
    logic [W-1:0]        cy;
    logic [W-2:0]        rad;
    logic [W:0]          opx;
    logic [W:0]          opy;
    logic                negx;
    logic                negy;
    logic [SQ_W-1:0]     d2;
    logic [E_W-1:0]      e;
  } s4_t;

  typedef struct packed {
    cpf_pkg::side_t      side;
    logic                is_circ;
    logic                pass;
    logic [W:0]          opx;
    logic [W:0]          opy;
    logic [EMAG_W-1:0]   mb;
    logic [DW-1:0]       den_line;
  } pay_t;

  typedef struct packed {
    cpf_pkg::side_t      side;
    logic [2*W:0]        plx;
    logic [2*W+1:0]      phx;
    logic [2*W:0]        ply;
    logic [2*W+1:0]      phy;
    logic [DW-1:0]       den;
  } s6_t;

  logic adv;
  logic out_valid_r;
  cpf_pkg::out_t out_r;

  // the whole pipeline moves unless a finished beat is held at the output
  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;

  // stage 1: input register
  logic         v1_r;
  cpf_pkg::in_t d1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d1_r <= in_data;
    end
  end

  // stage 2: differences and magnitudes
  logic   v2_r;
  s2_t    s2_r;
  s2_t    s2_nxt;
  logic [W:0]   dx, dy, mx, my;
  logic [W-1:0] ma, mb;

  always_comb begin
    dx = {d1_r.point_x[W-1], d1_r.point_x} - {d1_r.center_x[W-1], d1_r.center_x};
    dy = {d1_r.point_y[W-1], d1_r.point_y} - {d1_r.center_y[W-1], d1_r.center_y};
    mx = dx[W] ? ~dx + 1'b1 : dx;
    my = dy[W] ? ~dy + 1'b1 : dy;
    ma = d1_r.coef_a[W-1] ? ~d1_r.coef_a + 1'b1 : d1_r.coef_a;
    mb = d1_r.coef_b[W-1] ? ~d1_r.coef_b + 1'b1 : d1_r.coef_b;
    s2_nxt.is_circ = d1_r.action == cpf_pkg::ACT_CIRCLE;
    s2_nxt.is_line = d1_r.action == cpf_pkg::ACT_LINE;
    s2_nxt.px      = d1_r.point_x;
    s2_nxt.py      = d1_r.point_y;
    s2_nxt.cx      = d1_r.center_x;
    s2_nxt.cy      = d1_r.center_y;
    s2_nxt.rad     = d1_r.radius;
    s2_nxt.a       = d1_r.coef_a;
    s2_nxt.b       = d1_r.coef_b;
    s2_nxt.c       = d1_r.coef_c;
    s2_nxt.opx     = s2_nxt.is_circ ? mx : {1'b0, ma};
    s2_nxt.opy     = s2_nxt.is_circ ? my : {1'b0, mb};
    s2_nxt.negx    = s2_nxt.is_circ ? dx[W] : d1_r.coef_a[W-1];
    s2_nxt.negy    = s2_nxt.is_circ ? dy[W] : d1_r.coef_b[W-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_r <= s2_nxt;
    end
  end

  // stage 3: products
  logic v3_r;
  s3_t  s3_r;
  s3_t  s3_nxt;
  logic signed [2*W-1:0] apx, bpy;

  always_comb begin
    apx = s2_r.a * s2_r.px;
    bpy = s2_r.b * s2_r.py;
    s3_nxt.is_circ = s2_r.is_circ;
    s3_nxt.is_line = s2_r.is_line;
    s3_nxt.px      = s2_r.px;
    s3_nxt.py      = s2_r.py;
    s3_nxt.cx      = s2_r.cx;
    s3_nxt.cy      = s2_r.cy;
    s3_nxt.rad     = s2_r.rad;
    s3_nxt.c       = s2_r.c;
    s3_nxt.opx     = s2_r.opx;
    s3_nxt.opy     = s2_r.opy;
    s3_nxt.negx    = s2_r.negx;
    s3_nxt.negy    = s2_r.negy;
    s3_nxt.sqx     = s2_r.opx * s2_r.opx;
    s3_nxt.sqy     = s2_r.opy * s2_r.opy;
    s3_nxt.apx     = apx;
    s3_nxt.bpy     = bpy;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (adv) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_r <= s3_nxt;
    end
  end

  // stage 4: squared distance / denominator and line residual
  logic v4_r;
  s4_t  s4_r;
  s4_t  s4_nxt;
  logic [E_W-1:0] c_sh;

  always_comb begin
    c_sh = {{(E_W-W){s3_r.c[W-1]}}, s3_r.c} << cpf_pkg::FRAC_BITS;
    s4_nxt.is_circ = s3_r.is_circ;
    s4_nxt.is_line = s3_r.is_line;
    s4_nxt.px      = s3_r.px;
    s4_nxt.py      = s3_r.py;
    s4_nxt.cx      = s3_r.cx;
    s4_nxt.cy      = s3_r.cy;
    s4_nxt.rad     = s3_r.rad;
    s4_nxt.opx     = s3_r.opx;
    s4_nxt.opy     = s3_r.opy;
    s4_nxt.negx    = s3_r.negx;
    s4_nxt.negy    = s3_r.negy;
    s4_nxt.d2      = s3_r.sqx + s3_r.sqy;
    s4_nxt.e       = {{(E_W-2*W){s3_r.apx[2*W-1]}}, s3_r.apx}
                   + {{(E_W-2*W){s3_r.bpy[2*W-1]}}, s3_r.bpy} + c_sh;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (adv) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_r <= s4_nxt;
    end
  end

  // stage 5: classify, pick operands; enters the square root pipeline
  logic             sq_v_r    [ROOT_W+1];
  pay_t             sq_pay_r  [ROOT_W+1];
  logic [SQ_W-1:0]  sq_n_r    [ROOT_W+1];
  logic [SREM_W-1:0] sq_rem_r [ROOT_W+1];
  logic [ROOT_W-1:0] sq_root_r[ROOT_W+1];

  pay_t             pay_nxt;
  logic             deg, fig, eneg;
  logic [E_W-1:0]   emag;

  always_comb begin
    fig  = s4_r.is_circ || s4_r.is_line;
    deg  = s4_r.d2 == '0;
    eneg = s4_r.e[E_W-1];
    emag = eneg ? ~s4_r.e + 1'b1 : s4_r.e;
    pay_nxt.is_circ      = s4_r.is_circ;
    pay_nxt.pass         = !fig || deg;
    pay_nxt.side.status  = (fig && deg) ? cpf_pkg::ST_DEGEN : cpf_pkg::ST_OK;
    pay_nxt.side.base_x  = s4_r.is_circ ? s4_r.cx : s4_r.px;
    pay_nxt.side.base_y  = s4_r.is_circ ? s4_r.cy : s4_r.py;
    pay_nxt.side.neg_x   = s4_r.is_circ ? s4_r.negx : !(s4_r.negx ^ eneg);
    pay_nxt.side.neg_y   = s4_r.is_circ ? s4_r.negy : !(s4_r.negy ^ eneg);
    pay_nxt.opx          = pay_nxt.pass ? '0 : s4_r.opx;
    pay_nxt.opy          = pay_nxt.pass ? '0 : s4_r.opy;
    pay_nxt.mb           = s4_r.is_circ ? {{(EMAG_W-W+1){1'b0}}, s4_r.rad}
                                        : emag[EMAG_W-1:0];
    pay_nxt.den_line     = s4_r.d2[DW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_v_r[0] <= 1'b0;
    end else if (adv) begin
      sq_v_r[0] <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_pay_r[0]  <= pay_nxt;
      sq_n_r[0]    <= s4_r.d2;
      sq_rem_r[0]  <= '0;
      sq_root_r[0] <= '0;
    end
  end

  // integer square root, one result bit per stage
  for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
    logic [SREM_W-1:0] rem_sh, trial, rem_nxt;
    logic              ge;

    always_comb begin
      rem_sh  = {sq_rem_r[k][SREM_W-3:0], sq_n_r[k][SQ_W-1 -: 2]};
      trial   = {sq_root_r[k], 2'b01};
      ge      = rem_sh >= trial;
      rem_nxt = ge ? rem_sh - trial : rem_sh;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_v_r[k+1] <= 1'b0;
      end else if (adv) begin
        sq_v_r[k+1] <= sq_v_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sq_rem_r[k+1]  <= rem_nxt;
        sq_root_r[k+1] <= {sq_root_r[k][ROOT_W-2:0], ge};
        sq_n_r[k+1]    <= sq_n_r[k] << 2;
        sq_pay_r[k+1]  <= sq_pay_r[k];
      end
    end
  end

  // stage 6: numerator partial products, divisor select
  logic v6_r;
  s6_t  s6_r;
  s6_t  s6_nxt;
  pay_t pq;

  always_comb begin
    pq = sq_pay_r[ROOT_W];
    s6_nxt.side = pq.side;
    s6_nxt.plx  = pq.opx * pq.mb[ELO_W-1:0];
    s6_nxt.phx  = pq.opx * pq.mb[EMAG_W-1:ELO_W];
    s6_nxt.ply  = pq.opy * pq.mb[ELO_W-1:0];
    s6_nxt.phy  = pq.opy * pq.mb[EMAG_W-1:ELO_W];
    if (pq.pass) begin
      s6_nxt.den = {{(DW-1){1'b0}}, 1'b1};
    end else if (pq.is_circ) begin
      s6_nxt.den = {{(DW-ROOT_W){1'b0}}, sq_root_r[ROOT_W]};
    end else begin
      s6_nxt.den = pq.den_line;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r <= 1'b0;
    end else if (adv) begin
      v6_r <= sq_v_r[ROOT_W];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s6_r <= s6_nxt;
    end
  end

  // stage 7: assemble numerators
  logic           v7_r;
  logic [NW-1:0]  num_x_r, num_y_r;
  logic [DW-1:0]  den7_r;
  cpf_pkg::side_t side7_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v7_r <= 1'b0;
    end else if (adv) begin
      v7_r <= v6_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      num_x_r <= {{(NW-2*W-1){1'b0}}, s6_r.plx}
               + ({{(NW-2*W-2){1'b0}}, s6_r.phx} << ELO_W);
      num_y_r <= {{(NW-2*W-1){1'b0}}, s6_r.ply}
               + ({{(NW-2*W-2){1'b0}}, s6_r.phy} << ELO_W);
      den7_r  <= s6_r.den;
      side7_r <= s6_r.side;
    end
  end

  logic           dv_valid;
  logic [QB:0]    quot_x, quot_y;
  cpf_pkg::side_t dv_side;

  cpf_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_valid (v7_r),
    .num_x    (num_x_r),
    .num_y    (num_y_r),
    .den      (den7_r),
    .side     (side7_r),
    .out_valid(dv_valid),
    .quot_x   (quot_x),
    .quot_y   (quot_y),
    .side_out (dv_side)
  );

  // final stage: apply offset, saturate
  logic [SUM_W-1:0] off_x, off_y, sum_x, sum_y;
  logic             sat_x, sat_y;
  cpf_pkg::out_t    out_nxt;

  always_comb begin
    off_x = {{(SUM_W-QB-1){1'b0}}, quot_x};
    off_y = {{(SUM_W-QB-1){1'b0}}, quot_y};
    if (dv_side.neg_x) begin
      off_x = ~off_x + 1'b1;
    end
    if (dv_side.neg_y) begin
      off_y = ~off_y + 1'b1;
    end
    sum_x = {{(SUM_W-W){dv_side.base_x[W-1]}}, dv_side.base_x} + off_x;
    sum_y = {{(SUM_W-W){dv_side.base_y[W-1]}}, dv_side.base_y} + off_y;
    sat_x = (sum_x[SUM_W-1:W-1] != '0) && (sum_x[SUM_W-1:W-1] != '1);
    sat_y = (sum_y[SUM_W-1:W-1] != '0) && (sum_y[SUM_W-1:W-1] != '1);
    out_nxt.near_x = sat_x ? {sum_x[SUM_W-1], {(W-1){!sum_x[SUM_W-1]}}} : sum_x[W-1:0];
    out_nxt.near_y = sat_y ? {sum_y[SUM_W-1], {(W-1){!sum_y[SUM_W-1]}}} : sum_y[W-1:0];
    out_nxt.status = (sat_x || sat_y) ? cpf_pkg::ST_SAT : dv_side.status;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire

// ===== tb/tb_closest_point_on_figure_unit.sv =====
`default_nettype none
module tb_closest_point_on_figure_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_RANDOM  = 1800;
  localparam int LONG_HOLD = 400;

  // selector value with no figure behind it; behaves as a dot
  localparam logic [1:0] ACT_SPARE = 2'd3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  cpf_pkg::in_t  in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  cpf_pkg::out_t out_data;

  cpf_pkg::in_t  query_q[$];
  cpf_pkg::out_t nearest_q[$];
  int   mismatches = 0;
  int   accepted = 0;
  bit   in_fire = 1'b0;
  bit   stim_done = 1'b0;
  int   gap_left = 0;
  int   burst_left = 0;
  int   hold_left = 0;
  bit   held_long = 1'b0;
  int   stall_mode = 0;

  always #6 clk = ~clk;

  closest_point_on_figure_unit DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  function automatic logic [127:0] div_round(logic [127:0] n, logic [127:0] d);
    logic [127:0] q, r;
    q = n / d;
    r = n % d;
    if (r >= d - r) q = q + 1;
    return q;
  endfunction

  function automatic logic signed [127:0] sdiv_round(logic signed [127:0] n,
                                                     logic signed [127:0] d);
    logic [127:0] q;
    q = div_round(n < 0 ? -n : n, d);
    return n < 0 ? -$signed(q) : $signed(q);
  endfunction

  function automatic logic [127:0] isqrt(logic [127:0] n);
    logic [127:0] res, c;
    res = '0;
    for (int b = 63; b >= 0; b--) begin
      c = res | (128'd1 << b);
      if (c * c <= n) res = c;
    end
    return res;
  endfunction

  function automatic logic signed [cpf_pkg::COORD_WIDTH-1:0] clamp_coord(
      logic signed [127:0] v, inout bit sat);
    logic signed [127:0] hi, lo;
    hi = (128'sd1 <<< (cpf_pkg::COORD_WIDTH - 1)) - 1;
    lo = -(128'sd1 <<< (cpf_pkg::COORD_WIDTH - 1));
    if (v > hi) begin
      sat = 1'b1;
      return hi[cpf_pkg::COORD_WIDTH-1:0];
    end
    if (v < lo) begin
      sat = 1'b1;
      return lo[cpf_pkg::COORD_WIDTH-1:0];
    end
    return v[cpf_pkg::COORD_WIDTH-1:0];
  endfunction

  function automatic cpf_pkg::out_t nearest_point(cpf_pkg::in_t q);
    logic signed [127:0] px, py, cx, cy, dx, dy, mx, my, d2, root, ox, oy;
    logic signed [127:0] a, b, c, den, e, rx, ry;
    cpf_pkg::out_t r;
    bit sat;
    sat = 1'b0;
    px = q.point_x;
    py = q.point_y;
    rx = px;
    ry = py;
    r.status = cpf_pkg::ST_OK;
    if (q.action == cpf_pkg::ACT_CIRCLE) begin
      cx = q.center_x;
      cy = q.center_y;
      dx = px - cx;
      dy = py - cy;
      mx = dx < 0 ? -dx : dx;
      my = dy < 0 ? -dy : dy;
      d2 = mx * mx + my * my;
      if (d2 == 0) begin
        r.status = cpf_pkg::ST_DEGEN;
      end else begin
        root = isqrt(d2);
        ox = div_round(mx * q.radius, root);
        oy = div_round(my * q.radius, root);
        if (dx < 0) ox = -ox;
        if (dy < 0) oy = -oy;
        rx = cx + ox;
        ry = cy + oy;
      end
    end else if (q.action == cpf_pkg::ACT_LINE) begin
      a = q.coef_a;
      b = q.coef_b;
      c = q.coef_c;
      den = a * a + b * b;
      if (den == 0) begin
        r.status = cpf_pkg::ST_DEGEN;
      end else begin
        e = a * px + b * py + (c <<< cpf_pkg::FRAC_BITS);
        rx = px - sdiv_round(a * e, den);
        ry = py - sdiv_round(b * e, den);
      end
    end
    r.near_x = clamp_coord(rx, sat);
    r.near_y = clamp_coord(ry, sat);
    if (sat) r.status = cpf_pkg::ST_SAT;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("MISMATCH %s: got %h, want %h at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      1, 2: return $urandom;
      3: return $signed($urandom_range(0, 32'h0fffff)) - 32'sh80000;
      default: return $signed($urandom_range(0, 32'h7ffffff)) - 32'sh4000000;
    endcase
  endfunction

  function automatic cpf_pkg::in_t rand_query();
    cpf_pkg::in_t q;
    q.action   = $urandom_range(0, 9) == 0 ? ACT_SPARE : 2'($urandom_range(0, 2));
    q.point_x  = rand_coord();
    q.point_y  = rand_coord();
    q.center_x = rand_coord();
    q.center_y = rand_coord();
    q.radius   = $urandom_range(0, 1) ? 31'($urandom) : 31'($urandom_range(0, 32'h3ffffff));
    q.coef_a   = $urandom_range(0, 7) == 0 ? '0 : rand_coord();
    q.coef_b   = $urandom_range(0, 7) == 0 ? '0 : rand_coord();
    q.coef_c   = rand_coord();
    if ($urandom_range(0, 19) == 0) begin
      q.center_x = q.point_x;
      q.center_y = q.point_y;
    end
    return q;
  endfunction

  function automatic cpf_pkg::in_t make_query(logic [1:0] act, logic [31:0] px,
                                              logic [31:0] py, logic [31:0] cx,
                                              logic [31:0] cy, logic [30:0] rad,
                                              logic [31:0] a, logic [31:0] b,
                                              logic [31:0] c);
    cpf_pkg::in_t q;
    q.action = act; q.point_x = px; q.point_y = py; q.center_x = cx; q.center_y = cy;
    q.radius = rad; q.coef_a = a; q.coef_b = b; q.coef_c = c;
    return q;
  endfunction

  initial begin
    cpf_pkg::in_t q;
    query_q.push_back(make_query(cpf_pkg::ACT_DOT, 32'h7fffffff, 32'h80000000, 0, 0,
                                 31'd0, 0, 0, 0));
    query_q.push_back(make_query(ACT_SPARE, 32'h00010000, 32'hffff0000, 5, 5, 31'd5,
                                 5, 5, 5));
    query_q.push_back(make_query(cpf_pkg::ACT_CIRCLE, 32'h00030000, 32'h00040000,
                                 32'h00030000, 32'h00040000, 31'h10000, 0, 0, 0));
    query_q.push_back(make_query(cpf_pkg::ACT_CIRCLE, 32'h00030000, 32'h00040000, 0, 0,
                                 31'h20000, 0, 0, 0));
    query_q.push_back(make_query(cpf_pkg::ACT_CIRCLE, 32'h7fffffff, 32'h7fffffff,
                                 32'h7ff00000, 32'h7ff00000, 31'h7fffffff, 0, 0, 0));
    query_q.push_back(make_query(cpf_pkg::ACT_CIRCLE, 32'h80000000, 32'h7fffffff,
                                 32'h7fffffff, 32'h80000000, 31'h7fffffff, 0, 0, 0));
    query_q.push_back(make_query(cpf_pkg::ACT_CIRCLE, 32'h80000000, 32'h80000000,
                                 32'h7fffffff, 32'h7fffffff, 31'h0, 0, 0, 0));
    query_q.push_back(make_query(cpf_pkg::ACT_CIRCLE, 32'h00000001, 32'h0, 0, 0,
                                 31'h7fffffff, 0, 0, 0));
    query_q.push_back(make_query(cpf_pkg::ACT_LINE, 32'h00050000, 32'h00070000, 0, 0,
                                 31'd0, 0, 0, 32'h00010000));
    query_q.push_back(make_query(cpf_pkg::ACT_LINE, 32'h00050000, 32'h00070000, 0, 0,
                                 31'd0, 32'h00010000, 0, 32'hfffe0000));
    query_q.push_back(make_query(cpf_pkg::ACT_LINE, 32'h00050000, 32'h00070000, 0, 0,
                                 31'd0, 0, 32'h00010000, 32'hfffe0000));
    query_q.push_back(make_query(cpf_pkg::ACT_LINE, 32'h00050000, 32'hfff90000, 0, 0,
                                 31'd0, 32'h00010000, 32'h00010000, 32'h00010000));
    query_q.push_back(make_query(cpf_pkg::ACT_LINE, 32'h7fffffff, 32'h80000000, 0, 0,
                                 31'd0, 32'h80000000, 32'h80000000, 32'h7fffffff));
    query_q.push_back(make_query(cpf_pkg::ACT_LINE, 32'h80000000, 32'h80000000, 0, 0,
                                 31'd0, 32'h7fffffff, 32'h00000001, 32'h80000000));
    query_q.push_back(make_query(cpf_pkg::ACT_LINE, 32'h0, 32'h0, 0, 0, 31'd0,
                                 32'h00000001, 32'h00000001, 32'h7fffffff));
    query_q.push_back(make_query(cpf_pkg::ACT_LINE, 32'hffffffff, 32'hffffffff, 0, 0,
                                 31'd0, 32'hffffffff, 32'h80000000, 32'hffffffff));
    query_q.push_back(make_query(cpf_pkg::ACT_DOT, 32'h0, 32'hffffffff, 32'hffffffff,
                                 32'h0, 31'h7fffffff, 32'hffffffff, 32'hffffffff,
                                 32'hffffffff));
    for (int i = 0; i < N_RANDOM; i++) begin
      q = rand_query();
      query_q.push_back(q);
    end
  end

  // reset, then wait for drain
  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    wait (stim_done);
    wait (nearest_q.size() == 0);
    repeat (200) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_closest_point_on_figure_unit OK");
    end else begin
      $display("tb_closest_point_on_figure_unit NOT OK");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("tb_closest_point_on_figure_unit NOT OK");
    $finish;
  end

  // input side: accept, predict
  always @(posedge clk) begin
    in_fire <= rst_n && in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall) begin
      nearest_q.push_back(nearest_point(in_data));
      accepted++;
    end
  end

  // driver: bursts with gaps; hold the beat while stalled
  always @(negedge clk) begin
    if (rst_n && !(in_valid && !in_fire)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (query_q.size() > 0) begin
        in_data <= query_q.pop_front();
        in_valid <= 1'b1;
        if (burst_left == 0) burst_left = $urandom_range(1, 40);
        burst_left--;
        if (burst_left == 0) gap_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
      end else begin
        in_valid <= 1'b0;
        if (!in_valid || in_fire) stim_done = 1'b1;
      end
    end
  end

  // receiver stall pattern, with one long hold-off
  always @(negedge clk) begin
    if (!held_long && accepted >= 600) begin
      held_long = 1'b1;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      if ($urandom_range(0, 63) == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= $urandom_range(0, 3) == 0;
        2: out_stall <= $urandom_range(0, 1) == 1;
        default: out_stall <= $urandom_range(0, 3) != 0;
      endcase
    end
  end

  // monitor: compare against oldest prediction
  always @(posedge clk) begin
    cpf_pkg::out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (nearest_q.size() == 0) begin
        report_mismatch("unexpected beat", 64'(out_data), 64'd0);
      end else begin
        want = nearest_q.pop_front();
        if (out_data.near_x !== want.near_x)
          report_mismatch("near_x", 64'(out_data.near_x), 64'(want.near_x));
        if (out_data.near_y !== want.near_y)
          report_mismatch("near_y", 64'(out_data.near_y), 64'(want.near_y));
        if (out_data.status !== want.status)
          report_mismatch("status", 64'(out_data.status), 64'(want.status));
      end
    end
  end
endmodule
`default_nettype wire
